// ===== hdl/assert_macros.svh =====
// Assertion macros used by the list module of this project.
// The SYNTH variant expands to nothing so synthesis sees no assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// A property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// An antecedent that implies a consequent in the following cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define ASSERT_ALWAYS(label, clk, rst, prop, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// ===== hdl/iidl_pkg.sv =====
package iidl_pkg;

   // Default sizing of the list.
   localparam int DEPTH_DEFAULT       = 64;
   localparam int VALUE_WIDTH_DEFAULT = 32;

   // Fixed widths of the word fields.
   localparam int OP_WIDTH     = 3;
   localparam int POS_IN_WIDTH = 8;
   localparam int DATA_WIDTH   = 32;
   localparam int LEN_WIDTH    = 7;

   // Number of cells OR-ed together in the first level of the read tree.
   localparam int GROUP_SIZE = 8;

   // Operation codes.
   localparam logic [OP_WIDTH-1:0] OP_READ     = 3'd0;
   localparam logic [OP_WIDTH-1:0] OP_INS_HEAD = 3'd1;
   localparam logic [OP_WIDTH-1:0] OP_INS_TAIL = 3'd2;
   localparam logic [OP_WIDTH-1:0] OP_INS_AT   = 3'd3;
   localparam logic [OP_WIDTH-1:0] OP_DELETE   = 3'd4;

   // Broadcast to every cell for one operation.
   typedef struct packed {
      logic ins_en;
      logic del_en;
      logic rd_en;
   } cell_ctrl_type;

endpackage

// ===== hdl/iidl_cell.sv =====
module iidl_cell
   import iidl_pkg::*;
#(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT,
   parameter int POS_WIDTH   = POS_IN_WIDTH,
   parameter int INDEX       = 0
) (
   input  logic                   clock,
   input  cell_ctrl_type          ctrl,
   input  logic [POS_WIDTH-1:0]   position,
   input  logic [VALUE_WIDTH-1:0] left_value,
   input  logic [VALUE_WIDTH-1:0] right_value,
   input  logic [VALUE_WIDTH-1:0] new_value,
   output logic [VALUE_WIDTH-1:0] cell_value,
   output logic [VALUE_WIDTH-1:0] read_value
);

   localparam logic [POS_WIDTH-1:0] MyIndex = POS_WIDTH'(INDEX);

   logic [VALUE_WIDTH-1:0] value_ff;
   logic [VALUE_WIDTH-1:0] value_in;

   // Insert moves cells above the position up and loads the position itself;
   // delete pulls cells at or above the position down from the right.
   always_comb begin
      value_in = value_ff;
      if (ctrl.ins_en && (MyIndex > position)) begin
         value_in = left_value;
      end else if (ctrl.ins_en && (MyIndex == position)) begin
         value_in = new_value;
      end else if (ctrl.del_en && (MyIndex >= position)) begin
         value_in = right_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   // Only the addressed cell puts its value on the read tree.
   assign cell_value = value_ff;
   assign read_value = (ctrl.rd_en && (MyIndex == position)) ? value_ff : '0;

endmodule

// ===== hdl/indexed_insert_delete_list.sv =====
// Positional list of up to DEPTH signed values held in a row of cells, one
// value per cell. A word carries an operation (read, insert at head, insert
// at tail, insert at position, delete at position), a position and a value.
// Inserts shift every later cell up by one and deletes shift them down by
// one, all cells moving together in the cycle the word is accepted. Each
// response reports whether the operation took effect, the value and a found
// flag for reads, and the list length afterwards. One word is handled at a
// time, and its response is offered once both levels of the read tree are
// registered. The accept edge updates the cells and registers the first
// level of the OR tree that collects the read value; the second level is
// then registered into the response, which is held until the receiver takes
// it. A new word is accepted in the cycle after the response is taken.
// Stored values are undefined after reset until written; the length starts
// at zero.
`include "assert_macros.svh"

module indexed_insert_delete_list
   import iidl_pkg::*;
#(
   parameter int DEPTH       = DEPTH_DEFAULT,
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [OP_WIDTH-1:0]     req_operation,
   input  logic [POS_IN_WIDTH-1:0] req_position,
   input  logic signed [DATA_WIDTH-1:0] req_item_value,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [DATA_WIDTH-1:0] rsp_read_value,
   output logic                    rsp_found,
   output logic                    rsp_accepted,
   output logic [LEN_WIDTH-1:0]    rsp_length
);

   localparam int CNT_WIDTH = $clog2(DEPTH + 1);
   localparam int POS_WIDTH = (CNT_WIDTH > POS_IN_WIDTH) ? CNT_WIDTH : POS_IN_WIDTH;
   localparam int NUM_GROUPS = (DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;

   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_GATHER = 3'b010,
      S_SEND   = 3'b100
   } state_type;

   state_type state_ff;
   state_type state_in;

   logic [CNT_WIDTH-1:0] count_ff;
   logic [CNT_WIDTH-1:0] count_in;

   logic [VALUE_WIDTH-1:0] partial_ff [NUM_GROUPS];
   logic [VALUE_WIDTH-1:0] partial_in [NUM_GROUPS];

   logic signed [DATA_WIDTH-1:0] read_value_ff;
   logic signed [DATA_WIDTH-1:0] read_value_in;
   logic                         found_ff;
   logic                         found_in;
   logic                         accepted_ff;
   logic                         accepted_in;
   logic [LEN_WIDTH-1:0]         length_ff;
   logic [LEN_WIDTH-1:0]         length_in;

   logic                   req_fire;
   logic                   rsp_fire;
   logic [POS_WIDTH-1:0]   req_pos_ext;
   logic [POS_WIDTH-1:0]   count_ext;
   logic [POS_WIDTH-1:0]   target_pos;
   logic                   is_insert;
   logic                   not_full;
   logic                   ins_ok;
   logic                   del_ok;
   logic                   rd_ok;
   cell_ctrl_type          ctrl;
   logic [VALUE_WIDTH-1:0] new_value;
   logic [VALUE_WIDTH-1:0] gather_value;
   logic [DATA_WIDTH-1:0]  gather_word;

   logic [VALUE_WIDTH-1:0] cell_value [DEPTH];
   logic [VALUE_WIDTH-1:0] cell_read  [DEPTH];

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_SEND);
   assign req_fire  = req_valid && !req_stall;
   assign rsp_fire  = rsp_valid && !rsp_stall;

   // Decode the operation and check it against the current length.
   assign req_pos_ext = POS_WIDTH'(req_position);
   assign count_ext   = POS_WIDTH'(count_ff);
   assign not_full    = (count_ff < CNT_WIDTH'(DEPTH));

   always_comb begin
      target_pos = req_pos_ext;
      is_insert  = 1'b0;
      case (req_operation)
         OP_INS_HEAD: begin
            target_pos = '0;
            is_insert  = 1'b1;
         end
         OP_INS_TAIL: begin
            target_pos = count_ext;
            is_insert  = 1'b1;
         end
         OP_INS_AT: begin
            is_insert = 1'b1;
         end
         default: begin
            target_pos = req_pos_ext;
         end
      endcase
   end

   assign ins_ok = is_insert && not_full && (target_pos <= count_ext);
   assign del_ok = (req_operation == OP_DELETE) && (req_pos_ext < count_ext);
   assign rd_ok  = (req_operation == OP_READ) && (req_pos_ext < count_ext);

   assign ctrl.ins_en = req_fire && ins_ok;
   assign ctrl.del_en = req_fire && del_ok;
   assign ctrl.rd_en  = req_fire && rd_ok;

   // Bring the 32-bit value to the stored width.
   generate
      if (VALUE_WIDTH <= DATA_WIDTH) begin : g_narrow_in
         assign new_value = req_item_value[VALUE_WIDTH-1:0];
      end else begin : g_wide_in
         assign new_value = {{(VALUE_WIDTH - DATA_WIDTH){req_item_value[DATA_WIDTH-1]}},
                             req_item_value};
      end
   endgenerate

   // The row of cells; each end sees zero beyond the list.
   generate
      for (genvar i = 0; i < DEPTH; i++) begin : g_cell
         logic [VALUE_WIDTH-1:0] left_value;
         logic [VALUE_WIDTH-1:0] right_value;
         if (i == 0) begin : g_first
            assign left_value = '0;
         end else begin : g_mid_left
            assign left_value = cell_value[i-1];
         end
         if (i == DEPTH - 1) begin : g_last
            assign right_value = '0;
         end else begin : g_mid_right
            assign right_value = cell_value[i+1];
         end
         iidl_cell #(
            .VALUE_WIDTH (VALUE_WIDTH),
            .POS_WIDTH   (POS_WIDTH),
            .INDEX       (i)
         ) u_cell (
            .clock       (clock),
            .ctrl        (ctrl),
            .position    (target_pos),
            .left_value  (left_value),
            .right_value (right_value),
            .new_value   (new_value),
            .cell_value  (cell_value[i]),
            .read_value  (cell_read[i])
         );
      end
   endgenerate

   // First level of the read tree: OR within each group of cells.
   always_comb begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
         partial_in[g] = '0;
         for (int k = 0; k < GROUP_SIZE; k++) begin
            if (g * GROUP_SIZE + k < DEPTH) begin
               partial_in[g] = partial_in[g] | cell_read[g * GROUP_SIZE + k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
         partial_ff[g] <= partial_in[g];
      end
   end

   // Second level: OR the group results.
   always_comb begin
      gather_value = '0;
      for (int g = 0; g < NUM_GROUPS; g++) begin
         gather_value = gather_value | partial_ff[g];
      end
   end

   // Sign-extend or truncate the stored value to the 32-bit word.
   generate
      if (VALUE_WIDTH >= DATA_WIDTH) begin : g_wide_out
         assign gather_word = gather_value[DATA_WIDTH-1:0];
      end else begin : g_narrow_out
         assign gather_word = {{(DATA_WIDTH - VALUE_WIDTH){gather_value[VALUE_WIDTH-1]}},
                               gather_value};
      end
   endgenerate

   // Length and response registers.
   always_comb begin
      count_in      = count_ff;
      read_value_in = read_value_ff;
      found_in      = found_ff;
      accepted_in   = accepted_ff;
      length_in     = length_ff;
      if (req_fire) begin
         if (ins_ok) begin
            count_in = count_ff + CNT_WIDTH'(1);
         end else if (del_ok) begin
            count_in = count_ff - CNT_WIDTH'(1);
         end
         found_in    = rd_ok;
         accepted_in = rd_ok || ins_ok || del_ok;
         length_in   = LEN_WIDTH'(count_in);
      end
      if (state_ff == S_GATHER) begin
         read_value_in = gather_word;
      end
   end

   // Sequencer: accept, gather, send.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               state_in = S_GATHER;
            end
         end
         S_GATHER: begin
            state_in = S_SEND;
         end
         S_SEND: begin
            if (rsp_fire) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      read_value_ff <= read_value_in;
      found_ff      <= found_in;
      accepted_ff   <= accepted_in;
      length_ff     <= length_in;
   end

   assign rsp_read_value = read_value_ff;
   assign rsp_found      = found_ff;
   assign rsp_accepted   = accepted_ff;
   assign rsp_length     = length_ff;

   // The length never passes the capacity.
   `ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CNT_WIDTH'(DEPTH), "length above capacity")
   // A found read is always an accepted one.
   `ASSERT_ALWAYS(a_found_accepted, clock, reset, !(rsp_valid && rsp_found && !rsp_accepted), "found without accepted")
   // A successful insert grows the list by exactly one.
   `ASSERT_NEXT(a_ins_grow, clock, reset, req_fire && ins_ok, count_ff == $past(count_ff) + CNT_WIDTH'(1), "insert did not grow list")
   // A successful delete shrinks the list by exactly one.
   `ASSERT_NEXT(a_del_shrink, clock, reset, req_fire && del_ok, count_ff == $past(count_ff) - CNT_WIDTH'(1), "delete did not shrink list")
   // The length only changes when a word is accepted.
   `ASSERT_NEXT(a_count_hold, clock, reset, !req_fire, count_ff == $past(count_ff), "length changed while idle")

endmodule

// ===== verif/testbench.sv =====
module testbench;
   import iidl_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int LIST_DEPTH = DEPTH_DEFAULT;

   // Operation codes that the block treats as no-ops.
   localparam logic [OP_WIDTH-1:0] OP_UNUSED_LO  = 3'd5;
   localparam logic [OP_WIDTH-1:0] OP_UNUSED_MID = 3'd6;
   localparam logic [OP_WIDTH-1:0] OP_UNUSED_HI  = 3'd7;

   localparam int HOLD_OFF_CYCLES = 300;
   localparam int DRAIN_LIMIT     = 2000;
   localparam int TAIL_CYCLES     = 10;
   localparam int WORDS_PER_PHASE = 330;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] read_value;
      logic                         found;
      logic                         accepted;
      logic [LEN_WIDTH-1:0]         length;
   } list_result_t;

   typedef struct packed {
      logic [OP_WIDTH-1:0]          op;
      logic [POS_IN_WIDTH-1:0]      pos;
      logic signed [DATA_WIDTH-1:0] val;
      logic                         has_golden;
      list_result_t                 golden;
   } directed_row_t;

   logic                         clock;
   logic                         reset;
   logic                         req_valid;
   logic                         req_stall;
   logic [OP_WIDTH-1:0]          req_operation;
   logic [POS_IN_WIDTH-1:0]      req_position;
   logic signed [DATA_WIDTH-1:0] req_item_value;
   logic                         rsp_valid;
   logic                         rsp_stall;
   logic signed [DATA_WIDTH-1:0] rsp_read_value;
   logic                         rsp_found;
   logic                         rsp_accepted;
   logic [LEN_WIDTH-1:0]         rsp_length;

   // Predicted contents of the list.
   logic signed [DATA_WIDTH-1:0] list_cells [LIST_DEPTH];
   int                           list_len;

   list_result_t  pending_results [$];
   directed_row_t directed_rows [24];

   // Typed-in result for the word on offer, when the directed table has one.
   logic          word_has_golden;
   list_result_t  word_golden;

   int error_count;
   int words_sent;
   int send_idle_pct;
   int recv_idle_pct;
   int hold_left;
   bit hold_request;

   indexed_insert_delete_list dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_operation  (req_operation),
      .req_position   (req_position),
      .req_item_value (req_item_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_read_value (rsp_read_value),
      .rsp_found      (rsp_found),
      .rsp_accepted   (rsp_accepted),
      .rsp_length     (rsp_length)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // Inserts a value at a position, shifting later cells up. Returns whether it took.
   function automatic logic insert_cell(input int pos, input logic signed [DATA_WIDTH-1:0] val);
      if (list_len >= LIST_DEPTH || pos > list_len) return 1'b0;
      for (int i = list_len; i > pos; i--) list_cells[i] = list_cells[i - 1];
      list_cells[pos] = val;
      list_len++;
      return 1'b1;
   endfunction

   // Applies one word to the predicted list and returns the response it should produce.
   function automatic list_result_t apply_list_op(input logic [OP_WIDTH-1:0] op,
                                                  input logic [POS_IN_WIDTH-1:0] pos,
                                                  input logic signed [DATA_WIDTH-1:0] val);
      list_result_t r;
      r = '0;
      case (op)
         OP_READ: begin
            if (int'(pos) < list_len) begin
               r.read_value = list_cells[int'(pos)];
               r.found      = 1'b1;
               r.accepted   = 1'b1;
            end
         end
         OP_INS_HEAD: r.accepted = insert_cell(0, val);
         OP_INS_TAIL: r.accepted = insert_cell(list_len, val);
         OP_INS_AT:   r.accepted = insert_cell(int'(pos), val);
         OP_DELETE: begin
            if (int'(pos) < list_len) begin
               for (int i = int'(pos); i + 1 < list_len; i++) list_cells[i] = list_cells[i + 1];
               list_len--;
               r.accepted = 1'b1;
            end
         end
         default: ;
      endcase
      r.length = list_len[LEN_WIDTH-1:0];
      return r;
   endfunction

   // Check each taken response against the oldest prediction, then predict any accepted word.
   always @(posedge clock) begin : check_words
      list_result_t got;
      list_result_t want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_read_value, rsp_found, rsp_accepted, rsp_length};
            if (pending_results.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("response with nothing expected: value=%h found=%b acc=%b len=%0d",
                           got.read_value, got.found, got.accepted, got.length);
            end else begin
               want = pending_results.pop_front();
               if (got !== want) begin
                  error_count++;
                  if (error_count <= 10)
                     $display("mismatch: expected value=%h found=%b acc=%b len=%0d, got value=%h found=%b acc=%b len=%0d",
                              want.read_value, want.found, want.accepted, want.length,
                              got.read_value, got.found, got.accepted, got.length);
               end
            end
         end
         if (req_valid && !req_stall) begin
            want = apply_list_op(req_operation, req_position, req_item_value);
            if (word_has_golden) want = word_golden;
            pending_results.push_back(want);
         end
      end
   end

   // The receiver stalls at random, or for a long stretch when asked.
   always @(negedge clock) begin
      if (hold_request) begin
         hold_left    = HOLD_OFF_CYCLES;
         hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // Offers one word after a random gap and returns at the falling edge after it is taken.
   task automatic drive_word(input logic [OP_WIDTH-1:0] op, input logic [POS_IN_WIDTH-1:0] pos,
                             input logic signed [DATA_WIDTH-1:0] val,
                             input logic has_golden, input list_result_t golden);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      word_has_golden = has_golden;
      word_golden     = golden;
      req_valid      <= 1'b1;
      req_operation  <= op;
      req_position   <= pos;
      req_item_value <= val;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (op <= OP_DELETE) words_sent++;
      @(negedge clock);
   endtask

   // Waits at the falling edge until every predicted response has arrived, giving up at the drain limit.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      for (int n = 0; n < DRAIN_LIMIT && pending_results.size() != 0; n++) @(negedge clock);
   endtask

   function automatic logic signed [DATA_WIDTH-1:0] pick_value();
      case ($urandom_range(0, 7))
         0:       return 32'sh7FFFFFFF;
         1:       return 32'sh80000000;
         2:       return 32'sh00000000;
         3:       return 32'shFFFFFFFF;
         default: return $urandom;
      endcase
   endfunction

   // Positions mostly near the live range of the list, sometimes anywhere.
   function automatic logic [POS_IN_WIDTH-1:0] pick_position();
      if ($urandom_range(0, 4) == 0) return POS_IN_WIDTH'($urandom_range(0, 255));
      return POS_IN_WIDTH'($urandom_range(0, list_len + 1));
   endfunction

   // Random sequences: fill to capacity, drain to empty, mixed operations and junk codes.
   task automatic run_random_words(input int target, input bit start_with_fill);
      int kind;
      logic [OP_WIDTH-1:0] op;
      target = words_sent + target;
      while (words_sent < target) begin
         kind = start_with_fill ? 0 : $urandom_range(0, 9);
         start_with_fill = 1'b0;
         if (kind == 0) begin
            while (list_len < LIST_DEPTH) begin
               op = OP_WIDTH'($urandom_range(OP_INS_HEAD, OP_INS_AT));
               drive_word(op, POS_IN_WIDTH'($urandom_range(0, list_len)), pick_value(),
                          1'b0, '0);
            end
            drive_word(OP_INS_HEAD, pick_position(), pick_value(), 1'b0, '0);
            drive_word(OP_INS_TAIL, pick_position(), pick_value(), 1'b0, '0);
            drive_word(OP_INS_AT, POS_IN_WIDTH'($urandom_range(0, LIST_DEPTH)), pick_value(),
                       1'b0, '0);
         end else if (kind == 1) begin
            while (list_len > 0) begin
               op = ($urandom_range(0, 2) == 0) ? OP_READ : OP_DELETE;
               drive_word(op, POS_IN_WIDTH'($urandom_range(0, list_len - 1)), $urandom,
                          1'b0, '0);
            end
            drive_word(OP_DELETE, pick_position(), $urandom, 1'b0, '0);
            drive_word(OP_READ, pick_position(), $urandom, 1'b0, '0);
         end else if (kind <= 3) begin
            repeat (5) drive_word(OP_WIDTH'($urandom_range(OP_READ, OP_UNUSED_HI)),
                                  POS_IN_WIDTH'($urandom_range(0, 255)), $urandom, 1'b0, '0);
         end else begin
            repeat (20) drive_word(OP_WIDTH'($urandom_range(OP_READ, OP_DELETE)),
                                   pick_position(), pick_value(), 1'b0, '0);
         end
      end
   endtask

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_operation   = OP_READ;
      req_position    = '0;
      req_item_value  = '0;
      rsp_stall       = 1'b0;
      word_has_golden = 1'b0;
      word_golden     = '0;
      error_count     = 0;
      words_sent      = 0;
      hold_left       = 0;
      hold_request    = 1'b0;
      list_len        = 0;
      for (int i = 0; i < LIST_DEPTH; i++) list_cells[i] = '0;
      send_idle_pct   = 26;
      recv_idle_pct   = 79;

      // Empty list, extremes of the value and position, refused inserts, junk codes.
      directed_rows[0]  = '{OP_READ,       8'd0,   32'sd0,        1'b1, '{32'sd0, 1'b0, 1'b0, 7'd0}};
      directed_rows[1]  = '{OP_DELETE,     8'd0,   32'sd0,        1'b1, '{32'sd0, 1'b0, 1'b0, 7'd0}};
      directed_rows[2]  = '{OP_INS_AT,     8'd1,   32'sh00001234, 1'b1, '{32'sd0, 1'b0, 1'b0, 7'd0}};
      directed_rows[3]  = '{OP_UNUSED_HI,  8'hFF,  32'shFFFFFFFF, 1'b1, '{32'sd0, 1'b0, 1'b0, 7'd0}};
      directed_rows[4]  = '{OP_INS_HEAD,   8'd0,   32'sh7FFFFFFF, 1'b1, '{32'sd0, 1'b0, 1'b1, 7'd1}};
      directed_rows[5]  = '{OP_INS_TAIL,   8'hFF,  32'sh80000000, 1'b1, '{32'sd0, 1'b0, 1'b1, 7'd2}};
      directed_rows[6]  = '{OP_INS_AT,     8'd2,   32'shFFFFFFFF, 1'b1, '{32'sd0, 1'b0, 1'b1, 7'd3}};
      directed_rows[7]  = '{OP_READ,       8'd0,   32'sd0,        1'b1, '{32'sh7FFFFFFF, 1'b1, 1'b1, 7'd3}};
      directed_rows[8]  = '{OP_READ,       8'd1,   32'sd0,        1'b1, '{32'sh80000000, 1'b1, 1'b1, 7'd3}};
      directed_rows[9]  = '{OP_READ,       8'd2,   32'sd0,        1'b1, '{32'shFFFFFFFF, 1'b1, 1'b1, 7'd3}};
      directed_rows[10] = '{OP_READ,       8'd3,   32'sd0,        1'b1, '{32'sd0, 1'b0, 1'b0, 7'd3}};
      directed_rows[11] = '{OP_READ,       8'hFF,  32'sd0,        1'b1, '{32'sd0, 1'b0, 1'b0, 7'd3}};
      directed_rows[12] = '{OP_INS_AT,     8'd4,   32'sh00005A5A, 1'b1, '{32'sd0, 1'b0, 1'b0, 7'd3}};
      directed_rows[13] = '{OP_INS_AT,     8'd1,   32'sd0,        1'b0, '0};
      directed_rows[14] = '{OP_INS_HEAD,   8'hAA,  32'sh55555555, 1'b0, '0};
      directed_rows[15] = '{OP_READ,       8'd1,   32'sd0,        1'b0, '0};
      directed_rows[16] = '{OP_READ,       8'd2,   32'shAAAAAAAA, 1'b0, '0};
      directed_rows[17] = '{OP_DELETE,     8'd4,   32'sd0,        1'b0, '0};
      directed_rows[18] = '{OP_DELETE,     8'd4,   32'sd0,        1'b0, '0};
      directed_rows[19] = '{OP_DELETE,     8'd0,   32'sd0,        1'b0, '0};
      directed_rows[20] = '{OP_UNUSED_LO,  8'h55,  32'sh55555555, 1'b1, '{32'sd0, 1'b0, 1'b0, 7'd3}};
      directed_rows[21] = '{OP_UNUSED_MID, 8'hAA,  32'shAAAAAAAA, 1'b1, '{32'sd0, 1'b0, 1'b0, 7'd3}};
      directed_rows[22] = '{OP_DELETE,     8'hFF,  32'sd0,        1'b0, '0};
      directed_rows[23] = '{OP_READ,       8'd0,   32'sd0,        1'b0, '0};

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         drive_word(directed_rows[i].op, directed_rows[i].pos, directed_rows[i].val,
                    directed_rows[i].has_golden, directed_rows[i].golden);

      // Sender pauses until the block has answered everything.
      wait_for_drain();

      // First phase opens with a long receiver hold-off while words keep coming,
      // and with a fill so the full-list refusals are reached early.
      hold_request = 1'b1;
      run_random_words(WORDS_PER_PHASE, 1'b1);
      wait_for_drain();

      send_idle_pct = 79;
      recv_idle_pct = 26;
      run_random_words(WORDS_PER_PHASE, 1'b0);
      wait_for_drain();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_random_words(WORDS_PER_PHASE, 1'b0);

      wait_for_drain();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (pending_results.size() != 0) begin
         error_count++;
         $display("%0d responses never arrived", pending_results.size());
      end

      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ===== indexed_insert_delete_list.f =====
+incdir+hdl
hdl/iidl_pkg.sv
hdl/iidl_cell.sv
hdl/indexed_insert_delete_list.sv
verif/testbench.sv
